FILE: design/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion that is switched off while reset is applied
`define MH2_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that is also checked while reset is applied
`define MH2_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/mh2_pkg.sv
// package with constants, types and helpers of the murmur2 stream hash
package mh2_pkg;

  // hash constants
  localparam logic [63:0] M64    = 64'hc6a4a7935bd1e995;
  localparam logic [31:0] M32    = 32'h5bd1e995;
  localparam logic [31:0] M64_LO = M64[31:0];
  localparam logic [31:0] M64_HI = M64[63:32];
  localparam int unsigned R64    = 47;
  localparam int unsigned R32    = 24;
  localparam int unsigned FIN_A32 = 13;
  localparam int unsigned FIN_B32 = 15;

  // chunk sizes in bytes
  localparam logic [3:0] SIZE64 = 4'd8;
  localparam logic [3:0] SIZE32 = 4'd4;

  // depth of the queue between front and back
  localparam int unsigned QDEPTH = 2;

  // one classified request handed from front to back
  typedef struct packed {
    logic        wide;
    logic        seed;
    logic        body;
    logic        tail;
    logic        fin;
    logic [31:0] len;
    logic [63:0] chunk;
  } mh2_op_t;

  // phases of the back engine
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SEED,
    PH_K1,
    PH_K2,
    PH_H,
    PH_TAIL,
    PH_FIN
  } mh2_phase_e;

  // mask of the low n bytes, all ones from eight bytes up
  function automatic logic [63:0] byte_mask(input logic [3:0] n);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      m[8*i +: 8] = (4'(i) < n) ? 8'hff : 8'h00;
    end
    return m;
  endfunction

endpackage

FILE: design/mh2_stream_if.sv
// request and result channel interfaces of the murmur2 stream hash
interface mh2_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] chunk;
  logic [3:0]  byte_count;
  logic        first;
  logic        last;
  logic [31:0] message_length;

  modport source (output valid, chunk, byte_count, first, last, message_length,
                  input ready);
  modport sink   (input valid, chunk, byte_count, first, last, message_length,
                  output ready);
endinterface

interface mh2_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink   (input valid, hash_value, output ready);
endinterface

FILE: design/murmur2_stream_hash.sv
// top level of the murmur2 / murmur64a stream hash
//
//  channel   dir  handshake           payload
//  req_i     in   valid / ready       chunk, byte_count, first, last, message_length
//  rsp_o     out  valid / ready       hash_value
//  cfg       in   cfg_we_i (no wait)  cfg_wdata_i = wide_mode
//
// the front takes a request per cycle while the two-entry queue has room
// the back runs each request on its one 32x32 multiplier, building each multiply
// from partial products and a write-back step: a full chunk is 3 multiplies, the
// 64-bit seed, a tail and the finalization 1 each; the result sits in an output
// register, so the back keeps working while it waits, up to the next finalization
// reset is asynchronous, active low, and leaves the block idle in 64-bit mode
module murmur2_stream_hash (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  mh2_in_if.sink    req_i,
  mh2_out_if.source rsp_o
);

  logic             push;
  mh2_pkg::mh2_op_t push_op;
  logic             q_full;
  logic             q_valid;
  logic             q_pop;
  mh2_pkg::mh2_op_t q_op;

  // request intake and classification
  mh2_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .push_o      (push),
    .push_op_o   (push_op),
    .full_i      (q_full)
  );

  // queue between front and back
  mh2_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_op_i (push_op),
    .full_o    (q_full),
    .pop_i     (q_pop),
    .valid_o   (q_valid),
    .pop_op_o  (q_op)
  );

  // hash engine
  mh2_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_op_i    (q_op),
    .q_pop_o   (q_pop),
    .rsp_o     (rsp_o)
  );

endmodule

FILE: design/mh2_front.sv
// front part: takes requests, tracks the open message and classifies the work
module mh2_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i,
  mh2_in_if.sink           req_i,
  output logic             push_o,
  output mh2_pkg::mh2_op_t push_op_o,
  input  logic             full_i
);

  logic wide_mode_q, wide_mode_d;
  logic in_msg_q, in_msg_d;
  logic accept;
  logic active;
  logic full_chunk;
  logic [3:0] size;

  // mode register
  always_comb begin
    wide_mode_d = cfg_we_i ? cfg_wdata_i : wide_mode_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wide_mode_q <= 1'b1;
    end else begin
      wide_mode_q <= wide_mode_d;
    end
  end

  // handshake and classification
  assign req_i.ready = !full_i;
  assign accept      = req_i.valid && req_i.ready;
  assign active      = req_i.first || in_msg_q;
  assign size        = wide_mode_q ? mh2_pkg::SIZE64 : mh2_pkg::SIZE32;
  assign full_chunk  = (req_i.byte_count >= size);

  always_comb begin
    push_op_o.wide  = wide_mode_q;
    push_op_o.seed  = req_i.first;
    push_op_o.body  = full_chunk;
    push_op_o.tail  = !full_chunk && req_i.last && (req_i.byte_count != 4'd0);
    push_op_o.fin   = req_i.last;
    push_op_o.len   = req_i.message_length;
    push_op_o.chunk = full_chunk ? req_i.chunk
                                 : (req_i.chunk & mh2_pkg::byte_mask(req_i.byte_count));
  end

  // ignored requests change nothing downstream
  assign push_o = accept && active && (req_i.first || full_chunk || req_i.last);

  // open message tracking
  always_comb begin
    in_msg_d = in_msg_q;
    if (accept) begin
      priority if (active && req_i.last) begin
        in_msg_d = 1'b0;
      end else if (req_i.first) begin
        in_msg_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_msg_q <= 1'b0;
    end else begin
      in_msg_q <= in_msg_d;
    end
  end

endmodule

FILE: design/mh2_queue.sv
// short queue of classified requests between front and back
module mh2_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  mh2_pkg::mh2_op_t push_op_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output mh2_pkg::mh2_op_t pop_op_o
);

  localparam int unsigned PTR_W = (mh2_pkg::QDEPTH > 1) ? $clog2(mh2_pkg::QDEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(mh2_pkg::QDEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(mh2_pkg::QDEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(mh2_pkg::QDEPTH);

  mh2_pkg::mh2_op_t mem_q [mh2_pkg::QDEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o   = (cnt_q == CNT_FULL);
  assign valid_o  = (cnt_q != '0);
  assign pop_op_o = mem_q[rd_ptr_q];
  assign do_push  = push_i && !full_o;
  assign do_pop   = pop_i && valid_o;

  // pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CNT_W'(1);
      2'b01:   cnt_d = cnt_q - CNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

endmodule

FILE: design/mh2_back.sv
// back part: runs seed, body, tail and final steps on a shared 32x32 multiplier
module mh2_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  mh2_pkg::mh2_op_t q_op_i,
  output logic             q_pop_o,
  mh2_out_if.source        rsp_o
);

  // last multiply step is followed by one write-back step
  localparam logic [1:0] WB_WIDE   = 2'd3;
  localparam logic [1:0] WB_NARROW = 2'd1;

  mh2_pkg::mh2_phase_e phase_q, phase_d;
  mh2_pkg::mh2_op_t    op_q, op_d;
  logic [63:0] h_q, h_d;
  logic [63:0] k_q, k_d;
  logic [63:0] acc_q, acc_d;
  logic [1:0]  step_q, step_d;
  logic        out_valid_q, out_valid_d;
  logic [63:0] out_data_q, out_data_d;

  logic [63:0] x;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic        wb;
  logic        out_free;
  logic [31:0] k32_mix, h32_mix, a32_fin;
  logic [63:0] k64_mix, h64_mix, a64_fin;

  // phase that follows the seed step
  function automatic mh2_pkg::mh2_phase_e after_seed(input mh2_pkg::mh2_op_t op);
    mh2_pkg::mh2_phase_e p;
    priority if (op.body) begin
      p = mh2_pkg::PH_K1;
    end else if (op.tail) begin
      p = mh2_pkg::PH_TAIL;
    end else if (op.fin) begin
      p = mh2_pkg::PH_FIN;
    end else begin
      p = mh2_pkg::PH_IDLE;
    end
    return p;
  endfunction

  // xor-shift mixes
  assign k32_mix = k_q[31:0] ^ (k_q[31:0] >> mh2_pkg::R32);
  assign k64_mix = k_q ^ (k_q >> mh2_pkg::R64);
  assign h32_mix = h_q[31:0] ^ (h_q[31:0] >> mh2_pkg::FIN_A32);
  assign h64_mix = h_q ^ (h_q >> mh2_pkg::R64);
  assign a32_fin = acc_q[31:0] ^ (acc_q[31:0] >> mh2_pkg::FIN_B32);
  assign a64_fin = acc_q ^ (acc_q >> mh2_pkg::R64);

  // multiplier operand for the current phase
  always_comb begin
    unique case (phase_q)
      mh2_pkg::PH_SEED: x = {32'd0, op_q.len};
      mh2_pkg::PH_K1:   x = op_q.wide ? op_q.chunk : {32'd0, op_q.chunk[31:0]};
      mh2_pkg::PH_K2:   x = op_q.wide ? k64_mix : {32'd0, k32_mix};
      mh2_pkg::PH_H:    x = op_q.wide ? (h_q ^ k_q) : {32'd0, h_q[31:0]};
      mh2_pkg::PH_TAIL: x = op_q.wide ? (h_q ^ op_q.chunk)
                                      : {32'd0, h_q[31:0] ^ op_q.chunk[31:0]};
      mh2_pkg::PH_FIN:  x = op_q.wide ? h64_mix : {32'd0, h32_mix};
      default:          x = '0;
    endcase
  end

  // partial products: low x low, high x low, low x high
  // the low half of the 64-bit constant equals the 32-bit constant
  assign mul_a = (step_q == 2'd1) ? x[63:32] : x[31:0];
  assign mul_b = (step_q == 2'd2) ? mh2_pkg::M64_HI : mh2_pkg::M64_LO;
  assign prod  = mul_a * mul_b;

  assign wb       = (step_q == (op_q.wide ? WB_WIDE : WB_NARROW));
  assign out_free = !out_valid_q || rsp_o.ready;

  // sequencer and datapath next values
  always_comb begin
    phase_d     = phase_q;
    op_d        = op_q;
    h_d         = h_q;
    k_d         = k_q;
    acc_d       = acc_q;
    step_d      = step_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    q_pop_o     = 1'b0;

    if (phase_q == mh2_pkg::PH_IDLE) begin
      // take the next request
      if (q_valid_i) begin
        q_pop_o = 1'b1;
        op_d    = q_op_i;
        step_d  = 2'd0;
        if (q_op_i.seed && q_op_i.wide) begin
          phase_d = mh2_pkg::PH_SEED;
        end else begin
          if (q_op_i.seed) begin
            h_d = {32'd0, q_op_i.len};
          end
          phase_d = after_seed(q_op_i);
        end
      end
    end else if (!wb) begin
      // one partial product per cycle
      acc_d  = (step_q == 2'd0) ? prod : {acc_q[63:32] + prod[31:0], acc_q[31:0]};
      step_d = step_q + 2'd1;
    end else begin
      // write back the finished product
      unique case (phase_q)
        mh2_pkg::PH_SEED: begin
          h_d     = acc_q;
          step_d  = 2'd0;
          phase_d = after_seed(op_q);
        end
        mh2_pkg::PH_K1: begin
          k_d     = op_q.wide ? acc_q : {32'd0, acc_q[31:0]};
          step_d  = 2'd0;
          phase_d = mh2_pkg::PH_K2;
        end
        mh2_pkg::PH_K2: begin
          k_d     = op_q.wide ? acc_q : {32'd0, acc_q[31:0]};
          step_d  = 2'd0;
          phase_d = mh2_pkg::PH_H;
        end
        mh2_pkg::PH_H: begin
          h_d     = op_q.wide ? acc_q : {32'd0, acc_q[31:0] ^ k_q[31:0]};
          step_d  = 2'd0;
          phase_d = op_q.fin ? mh2_pkg::PH_FIN : mh2_pkg::PH_IDLE;
        end
        mh2_pkg::PH_TAIL: begin
          h_d     = op_q.wide ? acc_q : {32'd0, acc_q[31:0]};
          step_d  = 2'd0;
          phase_d = mh2_pkg::PH_FIN;
        end
        mh2_pkg::PH_FIN: begin
          // hold here while the previous result is still waiting
          if (out_free) begin
            h_d         = op_q.wide ? a64_fin : {32'd0, a32_fin};
            out_data_d  = op_q.wide ? a64_fin : {32'd0, a32_fin};
            out_valid_d = 1'b1;
            step_d      = 2'd0;
            phase_d     = mh2_pkg::PH_IDLE;
          end
        end
        default: begin
          step_d  = 2'd0;
          phase_d = mh2_pkg::PH_IDLE;
        end
      endcase
    end
  end

  // phase register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= mh2_pkg::PH_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= 2'd0;
      out_valid_q <= 1'b0;
      h_q         <= '0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      h_q         <= h_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    k_q        <= k_d;
    acc_q      <= acc_d;
    out_data_q <= out_data_d;
  end

  // result channel
  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.hash_value = out_data_q;

endmodule

FILE: design/mh2_checker.sv
// port-level checker of the murmur2 stream hash and its bind
`include "assert_macros.svh"

module mh2_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_first_i,
  input logic        in_last_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [63:0] out_hash_i
);

  logic       open_q, open_d;
  logic [2:0] pend_q, pend_d;
  logic       in_acc, out_acc, res_in;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;
  assign res_in  = in_acc && in_last_i && (in_first_i || open_q);

  // results owed for accepted requests
  always_comb begin
    open_d = open_q;
    if (in_acc) begin
      priority if (res_in) begin
        open_d = 1'b0;
      end else if (in_first_i) begin
        open_d = 1'b1;
      end
    end
    pend_d = pend_q + 3'(res_in) - 3'(out_acc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      pend_q <= 3'd0;
    end else begin
      open_q <= open_d;
      pend_q <= pend_d;
    end
  end

  `MH2_ASSERT_ALWAYS(a_no_result_in_reset, clk_i, !rst_ni |-> !out_valid_i, "result during reset")
  `MH2_ASSERT(a_result_owed, clk_i, rst_ni, out_acc |-> (pend_q != 3'd0), "result without request")
  `MH2_ASSERT(a_valid_holds, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i, "result dropped")
  `MH2_ASSERT(a_hash_holds, clk_i, rst_ni, out_valid_i && !out_ready_i |=> $stable(out_hash_i), "result changed")

endmodule

bind murmur2_stream_hash mh2_checker u_mh2_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_i.valid),
  .in_ready_i  (req_i.ready),
  .in_first_i  (req_i.first),
  .in_last_i   (req_i.last),
  .out_valid_i (rsp_o.valid),
  .out_ready_i (rsp_o.ready),
  .out_hash_i  (rsp_o.hash_value)
);
